// File: rtl/gmcp_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and table functions of the Gaussian cosine pulse generator.
package gmcp_pkg;

   localparam int REM_BITS  = 54;   // remainder width of the division cells
   localparam int DVSR_BITS = 53;   // 32 * spread^2
   localparam int U_BITS    = 21;   // quotient u, Q5.16
   localparam int E_BITS    = 31;   // envelope mantissa, Q30 up to one
   localparam int TAB_BITS  = 30;
   localparam int CR_BITS   = 34;   // CORDIC x, y, z width
   localparam int EXP_CELLS = 16;

   localparam logic [30:0] LOG2E_Q30       = 31'd1549082005;
   localparam logic [33:0] CORDIC_GAIN_Q30 = 34'd652032874;
   localparam logic [30:0] E_ONE           = 31'h4000_0000;
   localparam int          AMP_MAX         = 32767;

   localparam logic [1:0] REG_DELAY  = 2'd0;
   localparam logic [1:0] REG_SPREAD = 2'd1;
   localparam logic [1:0] REG_FREQ   = 2'd2;

   localparam logic [31:0] ATAN_TURNS [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
      32'h00000001, 32'h00000000
   };

   typedef struct packed {
      logic [REM_BITS-1:0] rem;
      logic [U_BITS-1:0]   quo;
      logic                zero;
   } div_type;

   typedef struct packed {
      logic [E_BITS-1:0] e;
      logic [U_BITS-1:0] v;
      logic              zero;
   } exp_type;

   typedef struct packed {
      logic signed [CR_BITS-1:0] x;
      logic signed [CR_BITS-1:0] y;
      logic signed [CR_BITS-1:0] z;
      logic                      neg;
   } cordic_type;

   // floor square root of a 64-bit value
   function automatic logic [63:0] isqrt64(input logic [63:0] a);
      logic [63:0] rem;
      logic [63:0] root;
      logic [63:0] bitv;
      rem  = a;
      root = '0;
      bitv = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (bitv > a) bitv = bitv >> 2;
      end
      for (int i = 0; i < 32; i++) begin
         if (bitv != 0) begin
            if (rem >= root + bitv) begin
               rem  = rem - (root + bitv);
               root = (root >> 1) + bitv;
            end else begin
               root = root >> 1;
            end
            bitv = bitv >> 2;
         end
      end
      return root;
   endfunction

   // 2^(-2^-k) in Q30, by repeated square roots from one half
   function automatic logic [TAB_BITS-1:0] exp_tab(input int k);
      logic [63:0] tab;
      tab = 64'h2000_0000;
      for (int i = 1; i <= k; i++) begin
         tab = isqrt64(tab << 30);
      end
      return tab[TAB_BITS-1:0];
   endfunction

endpackage

// File: rtl/gmcp_div_cell.sv
`timescale 1ns / 1ps
// One restoring-division cell: yields one quotient bit of u = d^2 / (2 s^2).
module gmcp_div_cell
   import gmcp_pkg::*;
(
   input  logic                 clock,
   input  logic                 en,
   input  logic [DVSR_BITS-1:0] dvsr,
   input  div_type              din,
   output div_type              dout
);

   logic                ge;
   logic [REM_BITS-1:0] diff;
   div_type             dout_in;
   div_type             dout_ff;

   always_comb begin
      ge   = din.rem >= {1'b0, dvsr};
      diff = ge ? din.rem - {1'b0, dvsr} : din.rem;
      dout_in.rem  = {diff[REM_BITS-2:0], 1'b0};
      dout_in.quo  = {din.quo[U_BITS-2:0], ge};
      dout_in.zero = din.zero;
   end

   always_ff @(posedge clock) begin
      if (en) dout_ff <= dout_in;
   end

   assign dout = dout_ff;

endmodule

// File: rtl/gmcp_exp_cell.sv
`timescale 1ns / 1ps
// One envelope cell: multiply by 2^(-2^-k) when its fraction bit of v is set.
module gmcp_exp_cell
   import gmcp_pkg::*;
#(
   parameter int                  BIT_POS = 15,
   parameter logic [TAB_BITS-1:0] TAB     = 30'd759250125
) (
   input  logic    clock,
   input  logic    en,
   input  exp_type din,
   output exp_type dout
);

   logic [E_BITS+TAB_BITS-1:0] prod;
   exp_type                    dout_in;
   exp_type                    dout_ff;

   always_comb begin
      prod = {{TAB_BITS{1'b0}}, din.e} * {{E_BITS{1'b0}}, TAB}
             + (E_BITS+TAB_BITS)'(64'd1 << 29);
      dout_in      = din;
      if (din.v[BIT_POS]) dout_in.e = prod[E_BITS+29:30];
   end

   always_ff @(posedge clock) begin
      if (en) dout_ff <= dout_in;
   end

   assign dout = dout_ff;

endmodule

// File: rtl/gmcp_cordic_cell.sv
`timescale 1ns / 1ps
// One rotation-mode CORDIC cell with a fixed shift.
module gmcp_cordic_cell
   import gmcp_pkg::*;
#(
   parameter int SHIFT = 0
) (
   input  logic       clock,
   input  logic       en,
   input  cordic_type din,
   output cordic_type dout
);

   localparam logic signed [CR_BITS-1:0] ATAN = {2'b00, ATAN_TURNS[SHIFT]};

   cordic_type dout_in;
   cordic_type dout_ff;

   always_comb begin
      dout_in = din;
      if (!din.z[CR_BITS-1]) begin
         dout_in.x = din.x - (din.y >>> SHIFT);
         dout_in.y = din.y + (din.x >>> SHIFT);
         dout_in.z = din.z - ATAN;
      end else begin
         dout_in.x = din.x + (din.y >>> SHIFT);
         dout_in.y = din.y - (din.x >>> SHIFT);
         dout_in.z = din.z + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (en) dout_ff <= dout_in;
   end

   assign dout = dout_ff;

endmodule

// File: rtl/gaussian_modulated_cosine_pulse.sv
`timescale 1ns / 1ps
// Top level of the Gaussian-modulated cosine pulse generator.
//
// For each signed time sample t the block returns
// exp(-((t - pulse_delay) / (pulse_spread * sqrt2))^2) * cos(2*pi*phase), with phase
// the low 32 bits of carrier_freq * t in Q0.32 turns, as a saturated signed Q1.15
// amplitude (+/-32767). The envelope is flushed to zero when its squared argument
// exceeds 16; a spread of zero counts as one. Throughput is one beat per clock while
// result beats are taken. The envelope chain sets the depth of the pipe: three entry
// stages (offset, square, far test), 21 restoring-division cells (one quotient bit
// each), one log2(e) multiply, 16 multiply cells for 2^-fraction, one shift, then
// the final product and the rounded output (two stages). The cosine runs alongside
// in CORDIC_STAGES cells and is delayed to meet the envelope. The whole pipe holds
// while a result beat waits unaccepted.
// Registers (APB, byte address 4*i): 0 pulse_delay, 1 pulse_spread, 2 carrier_freq.
// Write them only while the pipe is empty.
module gaussian_modulated_cosine_pulse
   import gmcp_pkg::*;
#(
   parameter int CORDIC_STAGES = 16,
   parameter int OUT_FRAC_BITS = 15
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_time_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_amplitude,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [3:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   localparam int LAT     = 44;
   localparam int COS_DLY = 38 - CORDIC_STAGES;
   localparam int SH      = 60 - OUT_FRAC_BITS;

   // ---------------- configuration registers ----------------
   logic        [31:0] delay_ff;
   logic        [23:0] spread_ff;
   logic        [31:0] freq_ff;
   logic        [23:0] spread_eff;
   logic        [47:0] s2_ff;
   logic        [1:0]  csr_idx;

   assign csr_idx    = csr_paddr[3:2];
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff  <= '0;
         spread_ff <= 24'd1;
         freq_ff   <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_idx)
            REG_DELAY:  delay_ff  <= csr_pwdata;
            REG_SPREAD: spread_ff <= csr_pwdata[23:0];
            REG_FREQ:   freq_ff   <= csr_pwdata;
            default:    ;   // drop writes beyond the register list
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_DELAY:  csr_prdata = delay_ff;
         REG_SPREAD: csr_prdata = {8'd0, spread_ff};
         REG_FREQ:   csr_prdata = freq_ff;
         default:    csr_prdata = '0;
      endcase
   end

   // spread^2 follows the register continuously; it is stable before any sample uses it
   assign spread_eff = (spread_ff == '0) ? 24'd1 : spread_ff;

   always_ff @(posedge clock) begin
      s2_ff <= spread_eff * spread_eff;
   end

   // ---------------- pipe control ----------------
   // Advance everything together; hold only while the output beat is not taken.
   logic           en;
   logic [LAT-1:0] vld_ff;

   assign en        = !vld_ff[LAT-1] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset)   vld_ff <= '0;
      else if (en) vld_ff <= {vld_ff[LAT-2:0], req_valid && req_ready};
   end

   // ---------------- stage 1: offset magnitude ----------------
   logic signed [32:0] d_in;
   logic        [32:0] ad_in;
   logic        [32:0] ad_ff;
   logic               big_ff;
   logic        [31:0] t_ff;

   assign d_in  = {req_time_value[31], req_time_value} - {delay_ff[31], delay_ff};
   assign ad_in = d_in[32] ? 33'(-d_in) : d_in;

   always_ff @(posedge clock) begin
      if (en) begin
         ad_ff  <= ad_in;
         big_ff <= ad_in > 33'd134217728;   // beyond 2^27 the envelope is surely zero
         t_ff   <= req_time_value;
      end
   end

   // ---------------- stage 2: squares and carrier phase ----------------
   logic [55:0] d2_ff;
   logic        zero_b_ff;
   logic [63:0] phase_prod;
   logic [31:0] phase_ff;

   assign phase_prod = {32'd0, freq_ff} * {32'd0, t_ff};

   always_ff @(posedge clock) begin
      if (en) begin
         d2_ff     <= {28'd0, ad_ff[27:0]} * {28'd0, ad_ff[27:0]};
         zero_b_ff <= big_ff;
         phase_ff  <= phase_prod[31:0];
      end
   end

   // ---------------- stage 3: far test and division start ----------------
   logic [DVSR_BITS-1:0] dvsr;
   div_type              div_link [0:U_BITS];
   div_type              div_start_ff;

   assign dvsr = {s2_ff, 5'b0};   // 16 * 2 * s^2: first cell weighs the 2^4 quotient bit

   always_ff @(posedge clock) begin
      if (en) begin
         div_start_ff.rem  <= d2_ff[REM_BITS-1:0];
         div_start_ff.quo  <= '0;
         div_start_ff.zero <= zero_b_ff || (d2_ff > {3'd0, dvsr});
      end
   end

   assign div_link[0] = div_start_ff;

   for (genvar i = 0; i < U_BITS; i++) begin : g_div
      gmcp_div_cell u_cell (
         .clock (clock),
         .en    (en),
         .dvsr  (dvsr),
         .din   (div_link[i]),
         .dout  (div_link[i+1])
      );
   end

   // ---------------- log2(e) scaling ----------------
   logic [51:0] vprod;
   exp_type     exp_link [0:EXP_CELLS];
   exp_type     exp_start_ff;

   assign vprod = {31'd0, div_link[U_BITS].quo} * {21'd0, LOG2E_Q30} + 52'(64'd1 << 29);

   always_ff @(posedge clock) begin
      if (en) begin
         exp_start_ff.e    <= E_ONE;
         exp_start_ff.v    <= vprod[50:30];
         exp_start_ff.zero <= div_link[U_BITS].zero;
      end
   end

   assign exp_link[0] = exp_start_ff;

   // cell k handles fraction bit 2^-k, most significant first
   for (genvar k = 1; k <= EXP_CELLS; k++) begin : g_exp
      gmcp_exp_cell #(
         .BIT_POS (EXP_CELLS - k),
         .TAB     (exp_tab(k))
      ) u_cell (
         .clock (clock),
         .en    (en),
         .din   (exp_link[k-1]),
         .dout  (exp_link[k])
      );
   end

   // ---------------- integer shift of the envelope ----------------
   logic [4:0]        env_n;
   logic [E_BITS-1:0] env_ff;

   assign env_n = exp_link[EXP_CELLS].v[20:16];

   always_ff @(posedge clock) begin
      if (en) begin
         if (exp_link[EXP_CELLS].zero || env_n >= 5'd31) env_ff <= '0;
         else env_ff <= exp_link[EXP_CELLS].e >> env_n;
      end
   end

   // ---------------- carrier: quadrant fold and CORDIC ----------------
   logic       fold_neg;
   logic [31:0] fold_p;
   cordic_type cr_link [0:CORDIC_STAGES];
   cordic_type cr_start_ff;
   logic signed [31:0] cos_ff;
   logic signed [31:0] cos_dly_ff [COS_DLY];

   assign fold_neg = (phase_ff[31:30] == 2'd1) || (phase_ff[31:30] == 2'd2);
   assign fold_p   = fold_neg ? {~phase_ff[31], phase_ff[30:0]} : phase_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         cr_start_ff.x   <= CORDIC_GAIN_Q30;
         cr_start_ff.y   <= '0;
         cr_start_ff.z   <= {{2{fold_p[31]}}, fold_p};
         cr_start_ff.neg <= fold_neg;
      end
   end

   assign cr_link[0] = cr_start_ff;

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      gmcp_cordic_cell #(
         .SHIFT (i)
      ) u_cell (
         .clock (clock),
         .en    (en),
         .din   (cr_link[i]),
         .dout  (cr_link[i+1])
      );
   end

   // undo the fold, then delay the cosine to meet the envelope
   always_ff @(posedge clock) begin
      if (en) begin
         cos_ff <= cr_link[CORDIC_STAGES].neg ? 32'(-cr_link[CORDIC_STAGES].x)
                                              : 32'(cr_link[CORDIC_STAGES].x);
         cos_dly_ff[0] <= cos_ff;
         for (int i = 1; i < COS_DLY; i++) cos_dly_ff[i] <= cos_dly_ff[i-1];
      end
   end

   // ---------------- product, rounding and saturation ----------------
   logic signed [63:0] prod_ff;
   logic signed [63:0] rnd;
   logic signed [63:0] amp_wide;
   logic signed [15:0] amp_in;
   logic signed [15:0] amp_ff;

   always_ff @(posedge clock) begin
      if (en) prod_ff <= 64'(signed'({1'b0, env_ff})) * 64'(cos_dly_ff[COS_DLY-1]);
   end

   always_comb begin
      rnd      = prod_ff + (64'sd1 <<< (SH - 1));
      amp_wide = rnd >>> SH;
      if (amp_wide > 64'(AMP_MAX))       amp_in = 16'(AMP_MAX);
      else if (amp_wide < 64'(-AMP_MAX)) amp_in = 16'(-AMP_MAX);
      else                               amp_in = amp_wide[15:0];
   end

   always_ff @(posedge clock) begin
      if (en) amp_ff <= amp_in;
   end

   assign rsp_amplitude = amp_ff;

endmodule
